/* rtl/cbspe_pkg.sv */
// shared constants and types for the clamped b-spline point evaluator
`default_nettype none

package cbspe_pkg;

    localparam int COORD_BITS_DEF      = 16;
    localparam int PARAM_FRAC_BITS_DEF = 16;

    // clock edges from the accepting edge to the edge that takes the result
    localparam int PIPE_LAT = 8;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CP0    = 3'd0,
        CFG_CP1    = 3'd1,
        CFG_CP2    = 3'd2,
        CFG_CP3    = 3'd3,
        CFG_DEGREE = 3'd4
    } t_cfg_idx;

    localparam logic [1:0] DEG_CUBIC = 2'd3;

endpackage

`default_nettype wire

/* rtl/clamped_bspline_point_eval_top.sv */
// clamped b-spline point evaluator: horner power-basis pipeline, three coordinate lanes
// o_valid is registered together with the result and is high in the cycle before the edge
//   that takes the result
// throughput: one parameter per clock when busy is low (fully pipelined multiply chain)
// reset: synchronous, active low; clears the pipeline valids, control points to zero,
//   degree to cubic; busy is high during reset and the first cycle after it
// o_valid is a one-cycle strobe, the receiver cannot stall the pipeline
`default_nettype none

module clamped_bspline_point_eval_top
    import cbspe_pkg::*;
#(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire  [PARAM_FRAC_BITS:0]           i_curve_param,
    output logic                               o_valid,
    output logic signed [COORD_BITS-1:0]       o_pos_x,
    output logic signed [COORD_BITS-1:0]       o_pos_y,
    output logic signed [COORD_BITS-1:0]       o_pos_z,
    input  wire                                i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]               i_cfg_idx,
    input  wire  [3*COORD_BITS-1:0]            i_cfg_data
);

    localparam int C    = COORD_BITS;
    localparam int F    = PARAM_FRAC_BITS;
    localparam int CW   = C + 4;          // power-basis coefficient width
    localparam int H1W  = C + F + 6;      // first horner value
    localparam int L1   = H1W / 2;
    localparam int U1   = H1W - L1;
    localparam int P1LW = L1 + F + 1;
    localparam int P1HW = U1 + F + 2;
    localparam int H2W  = C + 2*F + 7;    // second horner value
    localparam int L2   = H2W / 2;
    localparam int U2   = H2W - L2;
    localparam int P2LW = L2 + F + 1;
    localparam int P2HW = U2 + F + 2;
    localparam int H3W  = C + 3*F + 8;    // full-precision sum plus rounding half
    localparam int NST  = PIPE_LAT - 1;

    localparam logic [F:0] PARAM_ONE = {1'b1, {F{1'b0}}};

    logic [3*C-1:0] r_cp [4];
    logic [1:0]     r_degree;
    logic           r_busy;
    logic [NST-1:0] r_vld;
    logic [NST-1:0] r_oor;
    logic [F:0]     r_tp [5];
    logic           r_valid;
    logic signed [C-1:0] r_pos [3];
    logic           accept;
    logic           cubic;

    assign accept  = start && !r_busy;
    assign cubic   = (r_degree == DEG_CUBIC);
    assign busy    = r_busy;
    assign o_valid = r_valid;
    assign o_pos_x = r_pos[0];
    assign o_pos_y = r_pos[1];
    assign o_pos_z = r_pos[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp[0]  <= '0;
            r_cp[1]  <= '0;
            r_cp[2]  <= '0;
            r_cp[3]  <= '0;
            r_degree <= DEG_CUBIC;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CP0:    r_cp[0]  <= i_cfg_data;
                CFG_CP1:    r_cp[1]  <= i_cfg_data;
                CFG_CP2:    r_cp[2]  <= i_cfg_data;
                CFG_CP3:    r_cp[3]  <= i_cfg_data;
                CFG_DEGREE: r_degree <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // control: valid chain and busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_vld   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= 1'b0;
            r_vld   <= {r_vld[NST-2:0], accept};
            r_valid <= r_vld[NST-1];
        end
    end

    // parameter and out-of-range flag travel alongside the lanes
    always_ff @(posedge i_clk) begin
        r_oor   <= {r_oor[NST-2:0], (i_curve_param > PARAM_ONE)};
        r_tp[0] <= i_curve_param;
        r_tp[1] <= r_tp[0];
        r_tp[2] <= r_tp[1];
        r_tp[3] <= r_tp[2];
        r_tp[4] <= r_tp[3];
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        logic [C-1:0]         cp0c, cp1c, cp2c, cp3c;
        logic signed [CW-1:0] p0, p1, p2, p3, p0x3, p1x3, p2x3;
        logic signed [CW-1:0] n_a3, n_c2, n_c1;
        logic signed [C-1:0]  n_c0;
        logic signed [CW-1:0] r_a3, r_c2, r_c1;
        logic signed [C-1:0]  r_c0;
        logic signed [H1W-1:0] n_m1, r_m1, n_h1, r_h1;
        logic [P1LW-1:0]       n_pl2, r_pl2;
        logic signed [P1HW-1:0] n_ph2, r_ph2;
        logic signed [H2W-1:0] n_h2, r_h2;
        logic [P2LW-1:0]       n_pl3, r_pl3;
        logic signed [P2HW-1:0] n_ph3, r_ph3;
        logic signed [H3W-1:0] n_h3, r_h3;

        assign cp0c = r_cp[0][g*C +: C];
        assign cp1c = r_cp[1][g*C +: C];
        assign cp2c = r_cp[2][g*C +: C];
        assign cp3c = r_cp[3][g*C +: C];

        // bezier blend rewritten as a3*t^3 + c2*S*t^2 + c1*S^2*t + c0*S^3
        always_comb begin
            p0   = {{4{cp0c[C-1]}}, cp0c};
            p1   = {{4{cp1c[C-1]}}, cp1c};
            p2   = {{4{cp2c[C-1]}}, cp2c};
            p3   = {{4{cp3c[C-1]}}, cp3c};
            p0x3 = (p0 <<< 1) + p0;
            p1x3 = (p1 <<< 1) + p1;
            p2x3 = (p2 <<< 1) + p2;
            if (cubic) begin
                n_a3 = p3 - p2x3 + p1x3 - p0;
                n_c2 = p0x3 - (p1x3 <<< 1) + p2x3;
                n_c1 = p1x3 - p0x3;
                n_c0 = cp0c;
            end else begin
                // quadratic weights carry an extra factor S to share the cubic scale
                n_a3 = '0;
                n_c2 = p1 - (p2 <<< 1) + p3;
                n_c1 = (p2 <<< 1) - (p1 <<< 1);
                n_c0 = cp1c;
            end
        end

        always_comb begin
            n_m1  = r_a3 * $signed({1'b0, r_tp[0]});
            n_h1  = r_m1 + {{(H1W-F-CW){r_c2[CW-1]}}, r_c2, {F{1'b0}}};
            n_pl2 = r_h1[L1-1:0] * r_tp[2];
            n_ph2 = $signed(r_h1[H1W-1:L1]) * $signed({1'b0, r_tp[2]});
            n_h2  = {r_ph2[H2W-L1-1:0], {L1{1'b0}}}
                  + {{(H2W-P1LW){1'b0}}, r_pl2}
                  + {{(H2W-2*F-CW){r_c1[CW-1]}}, r_c1, {(2*F){1'b0}}};
            n_pl3 = r_h2[L2-1:0] * r_tp[4];
            n_ph3 = $signed(r_h2[H2W-1:L2]) * $signed({1'b0, r_tp[4]});
            // constant term also carries the rounding half
            n_h3  = {r_ph3[H3W-L2-1:0], {L2{1'b0}}}
                  + {{(H3W-P2LW){1'b0}}, r_pl3}
                  + {{(H3W-3*F-C){r_c0[C-1]}}, r_c0, 1'b1, {(3*F-1){1'b0}}};
        end

        always_ff @(posedge i_clk) begin
            r_a3  <= n_a3;
            r_c2  <= n_c2;
            r_c1  <= n_c1;
            r_c0  <= n_c0;
            r_m1  <= n_m1;
            r_h1  <= n_h1;
            r_pl2 <= n_pl2;
            r_ph2 <= n_ph2;
            r_h2  <= n_h2;
            r_pl3 <= n_pl3;
            r_ph3 <= n_ph3;
            r_h3  <= n_h3;
            r_pos[g] <= r_oor[NST-1] ? '0 : r_h3[3*F+C-1:3*F];
        end
    end

endmodule

`default_nettype wire

/* rtl/cbspe_chk.sv */
// port-level checker for the b-spline point evaluator, bound to the top level
`default_nettype none

module cbspe_chk
    import cbspe_pkg::*;
#(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          start,
    input wire                          busy,
    input wire [PARAM_FRAC_BITS:0]      i_curve_param,
    input wire                          o_valid,
    input wire [COORD_BITS-1:0]         o_pos_x,
    input wire [COORD_BITS-1:0]         o_pos_y,
    input wire [COORD_BITS-1:0]         o_pos_z
);

    localparam logic [PARAM_FRAC_BITS:0] PARAM_ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};

    // every accepted start is followed by a result strobe
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##PIPE_LAT o_valid)
        else $error("no result strobe after accepted start");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, PIPE_LAT))
        else $error("result strobe without matching start");

    // parameter beyond one lies in no knot span
    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ($past(i_curve_param, PIPE_LAT) > PARAM_ONE)
        |-> (o_pos_x == '0) && (o_pos_y == '0) && (o_pos_z == '0))
        else $error("out-of-range parameter gave a nonzero point");

endmodule

bind clamped_bspline_point_eval_top cbspe_chk #(
    .COORD_BITS      (COORD_BITS),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
) u_cbspe_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_curve_param (i_curve_param),
    .o_valid       (o_valid),
    .o_pos_x       (o_pos_x),
    .o_pos_y       (o_pos_y),
    .o_pos_z       (o_pos_z)
);

`default_nettype wire

/* tb/clamped_bspline_point_eval_top_test.sv */
// self-checking testbench for the clamped b-spline point evaluator
`timescale 1ns / 100ps

module clamped_bspline_point_eval_top_test;
    import cbspe_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int PF = PARAM_FRAC_BITS_DEF;
    localparam int BLEND_SHIFT = 3 * PF;
    localparam logic [PF:0] PARAM_ONE = (PF + 1)'(1) << PF;
    localparam logic [PF:0] PARAM_TOP = {(PF + 1){1'b1}};
    localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB - 1){1'b0}}};
    localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB - 1){1'b1}}};
    localparam int MAX_GAP = 18;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_PHASES = 16;

    typedef struct packed {
        logic signed [CB-1:0] z;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] x;
    } t_curve_point;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [PF:0]            i_curve_param;
    logic                   o_valid;
    logic signed [CB-1:0]   o_pos_x;
    logic signed [CB-1:0]   o_pos_y;
    logic signed [CB-1:0]   o_pos_z;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [3*CB-1:0]        i_cfg_data;

    // shadow copy of the curve registers
    logic [3*CB-1:0]        ctrl_pt [4];
    logic [1:0]             degree_reg;

    t_curve_point           pending_points [$];
    int                     err_count = 0;
    int                     cycle_count = 0;
    int                     burst_left = 0;

    clamped_bspline_point_eval_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_curve_param(i_curve_param),
        .o_valid      (o_valid),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_pos_z      (o_pos_z),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_points.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // exact bernstein blend, rounded half up at the 2^(3F) scale
    function automatic t_curve_point predict_point(input logic [PF:0] t);
        logic signed [127:0] tt;
        logic signed [127:0] uu;
        logic signed [127:0] one;
        logic signed [127:0] w [4];
        logic signed [127:0] acc;
        logic signed [127:0] cv;
        logic signed [CB-1:0] coord;
        logic signed [CB-1:0] res [3];
        t_curve_point p;
        p = '0;
        if (t > PARAM_ONE) return p;
        one = 128'(PARAM_ONE);
        tt = 128'(t);
        uu = one - tt;
        if (degree_reg == DEG_CUBIC) begin
            w[0] = uu * uu * uu;
            w[1] = 3 * tt * uu * uu;
            w[2] = 3 * tt * tt * uu;
            w[3] = tt * tt * tt;
        end else begin
            w[0] = '0;
            w[1] = uu * uu * one;
            w[2] = 2 * tt * uu * one;
            w[3] = tt * tt * one;
        end
        for (int c = 0; c < 3; c++) begin
            acc = '0;
            for (int i = 0; i < 4; i++) begin
                coord = ctrl_pt[i][c*CB +: CB];
                cv = 128'(coord);
                acc = acc + w[i] * cv;
            end
            acc = acc + (128'sd1 <<< (BLEND_SHIFT - 1));
            acc = acc >>> BLEND_SHIFT;
            res[c] = acc[CB-1:0];
        end
        p.x = res[0];
        p.y = res[1];
        p.z = res[2];
        return p;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_curve_point want;
        t_curve_point got;
        if (o_valid === 1'b1) begin
            got.x = o_pos_x;
            got.y = o_pos_y;
            got.z = o_pos_z;
            if (pending_points.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected result x=%0d y=%0d z=%0d", got.x, got.y, got.z);
            end else begin
                want = pending_points.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                                 want.x, want.y, want.z, got.x, got.y, got.z);
                end
            end
        end
    end

    // one parameter transfer; start stays high so back-to-back items need no gap
    task automatic send_param(input logic [PF:0] t, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_curve_param <= t;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_points.insert(pending_points.size(), predict_point(t));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [3*CB-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_CP0:    ctrl_pt[0] = data;
            CFG_CP1:    ctrl_pt[1] = data;
            CFG_CP2:    ctrl_pt[2] = data;
            CFG_CP3:    ctrl_pt[3] = data;
            CFG_DEGREE: degree_reg = data[1:0];
            default: ;
        endcase
    endtask

    task automatic load_curve(input logic [3*CB-1:0] p0, input logic [3*CB-1:0] p1,
                              input logic [3*CB-1:0] p2, input logic [3*CB-1:0] p3,
                              input logic [3*CB-1:0] deg_word);
        wait_idle();
        write_reg(CFG_CP0, p0);
        write_reg(CFG_CP1, p1);
        write_reg(CFG_CP2, p2);
        write_reg(CFG_CP3, p3);
        write_reg(CFG_DEGREE, deg_word);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [3*CB-1:0] pack_point(input logic signed [CB-1:0] x,
                                                   input logic signed [CB-1:0] y,
                                                   input logic signed [CB-1:0] z);
        return {z, y, x};
    endfunction

    function automatic logic signed [CB-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            default: return CB'($urandom);
        endcase
    endfunction

    function automatic logic [3*CB-1:0] pick_point();
        return pack_point(pick_coord(), pick_coord(), pick_coord());
    endfunction

    // degree word with junk in the upper bits, which the block must ignore
    function automatic logic [3*CB-1:0] degree_word(input logic [1:0] deg);
        logic [3*CB-1:0] w;
        w = (3 * CB)'({$urandom, $urandom});
        w[1:0] = deg;
        return w;
    endfunction

    function automatic logic [PF:0] pick_param();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return (PF + 1)'($urandom_range(PARAM_ONE + 1, PARAM_TOP));
        if (r < 14) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return (PF + 1)'(1);
                2: return (PF + 1)'(PARAM_ONE - 1);
                default: return PARAM_ONE;
            endcase
        end
        return (PF + 1)'($urandom_range(0, PARAM_ONE));
    endfunction

    function automatic int pick_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(20, 60);
        return $urandom_range(0, MAX_GAP);
    endfunction

    // reset registers: all points at the origin, cubic
    task automatic test_reset_state();
        send_param('0, 0);
        send_param(PARAM_ONE >> 1, pick_gap());
    endtask

    task automatic test_param_extremes();
        load_curve(pack_point(COORD_MIN, COORD_MAX, COORD_MIN),
                   pack_point(COORD_MAX, COORD_MIN, COORD_MAX),
                   pack_point(COORD_MIN, COORD_MIN, COORD_MAX),
                   pack_point(COORD_MAX, COORD_MAX, COORD_MIN),
                   degree_word(DEG_CUBIC));
        send_param('0, 0);
        send_param((PF + 1)'(1), 0);
        send_param((PF + 1)'(PARAM_ONE - 1), pick_gap());
        send_param(PARAM_ONE, pick_gap());
        // just past one: every span is empty
        send_param((PF + 1)'(PARAM_ONE + 1), 0);
        send_param(PARAM_TOP, pick_gap());
    endtask

    // degrees below two fall back to the quadratic blend; all four degree codes are run
    task automatic test_degree_modes();
        logic [3*CB-1:0] p [4];
        for (int i = 0; i < 4; i++) p[i] = pick_point();
        for (int d = 0; d < 4; d++) begin
            load_curve(p[0], p[1], p[2], p[3], degree_word(2'(d)));
            send_param('0, 0);
            send_param((PF + 1)'(PARAM_ONE / 3), pick_gap());
            send_param(PARAM_ONE, 0);
        end
    endtask

    // writes to indexes past the degree register change nothing
    task automatic test_unused_index();
        wait_idle();
        for (int k = CFG_DEGREE + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), (3 * CB)'({$urandom, $urandom}));
        i_cfg_we <= 1'b0;
        send_param(PARAM_ONE >> 2, 0);
        send_param(PARAM_ONE - (PARAM_ONE >> 3), pick_gap());
    endtask

    task automatic test_random_curves();
        int n;
        logic [1:0] deg;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            deg = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 2)) : DEG_CUBIC;
            if (ph == 0)
                load_curve(pack_point(COORD_MIN, COORD_MIN, COORD_MIN),
                           pack_point(COORD_MIN, COORD_MIN, COORD_MIN),
                           pack_point(COORD_MIN, COORD_MIN, COORD_MIN),
                           pack_point(COORD_MIN, COORD_MIN, COORD_MIN),
                           degree_word(DEG_CUBIC));
            else if (ph == 1)
                load_curve(pack_point(COORD_MAX, COORD_MAX, COORD_MAX),
                           pack_point(COORD_MAX, COORD_MAX, COORD_MAX),
                           pack_point(COORD_MAX, COORD_MAX, COORD_MAX),
                           pack_point(COORD_MAX, COORD_MAX, COORD_MAX),
                           degree_word(2'd2));
            else
                load_curve(pick_point(), pick_point(), pick_point(), pick_point(),
                           degree_word(deg));
            n = $urandom_range(80, 126);
            for (int k = 0; k < n; k++) begin
                // hold off mid-phase until the pipeline has emptied
                if (ph % 3 == 2 && k == n / 2) wait_idle();
                send_param(pick_param(), pick_gap());
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_curve_param <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        for (int i = 0; i < 4; i++) ctrl_pt[i] = '0;
        degree_reg = DEG_CUBIC;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_param_extremes();
        test_degree_modes();
        test_unused_index();
        test_random_curves();

        wait_idle();
        repeat (PIPE_LAT + 4) @(posedge i_clk);
        if (err_count == 0 && pending_points.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
